/* rtl/smt_pkg.sv */
// Shared types, constants and helpers for the sorted multiset table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package smt_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int FIELD_W = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Match flags summed per counter step
    localparam int CHUNK   = 8;
    localparam int CHUNK_W = $clog2(CHUNK + 1);

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                      cmp_en;
        logic                      ins_en;
        logic                      rem_en;
        logic signed [VALUE_W-1:0] value;
    } smt_ctrl_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid;
        logic                      gt;
    } smt_link_t;

    function automatic logic [CHUNK_W-1:0] popcount_chunk(input logic [CHUNK-1:0] bits);
        logic [CHUNK_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK; i++)
        begin
            n = n + CHUNK_W'(bits[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/smt_channels.sv */
// Handshake channels of the sorted multiset table: request and response.
// Depends on smt_pkg for field widths.
`default_nettype none

interface smt_req_if;
    import smt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface smt_rsp_if;
    import smt_pkg::*;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [FIELD_W-1:0] occurrences;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] distinct;

    modport source (output valid, output ok, output occurrences, output size,
                    output distinct, input ready);
    modport sink   (input valid, input ok, input occurrences, input size,
                    input distinct, output ready);
endinterface

`default_nettype wire

/* rtl/sorted_multiset_table.sv */
// Sorted multiset table: ascending chain of CAPACITY cells, one item at a time.
// The result is registered after the compare, load, count steps, done check and
// update. No new item is taken until the last one is through; the pace is set
// by the match counter that sums 8 cell flags per cycle. A stalled result holds
// the update step and delays the next item.
// Reset clears all valid bits and counts at once; no clearing pass is needed.
`default_nettype none

module sorted_multiset_table #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    smt_req_if.sink       req,
    smt_rsp_if.source     rsp
);
    import smt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_COMPARE = 3'd1;
    localparam logic [2:0] ST_LOAD    = 3'd2;
    localparam logic [2:0] ST_COUNT   = 3'd3;
    localparam logic [2:0] ST_UPDATE  = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          distinct_reg;
    logic [CNT_W-1:0]          distinct_next;
    logic                      rsp_valid_reg;
    logic                      rsp_ok_reg;
    logic [FIELD_W-1:0]        rsp_occ_reg;
    logic [FIELD_W-1:0]        rsp_size_reg;
    logic [FIELD_W-1:0]        rsp_distinct_reg;

    logic                      accept;
    logic                      out_free;
    logic                      commit;
    logic                      not_full;
    logic                      found;
    logic                      ok;
    logic                      cnt_load;
    logic                      cnt_done;
    logic [CNT_W-1:0]          occ;
    logic [CAPACITY-1:0]       eq_vec;
    smt_ctrl_t                 ctrl;
    smt_link_t                 links [CAPACITY];
    smt_link_t                 head;
    smt_link_t                 tail;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign commit   = (state_reg == ST_UPDATE) && out_free;
    assign not_full = count_reg < CNT_W'(CAPACITY);
    assign found    = (occ != '0);
    assign cnt_load = (state_reg == ST_LOAD);

    // Outcome of the item
    always_comb
    begin
        unique case (cmd_reg)
            CMD_INSERT: ok = not_full;
            CMD_REMOVE: ok = found;
            CMD_QUERY:  ok = found;
            default:    ok = 1'b0;
        endcase
    end

    // Broadcast control
    assign ctrl.cmp_en = (state_reg == ST_COMPARE);
    assign ctrl.ins_en = commit && (cmd_reg == CMD_INSERT) && not_full;
    assign ctrl.rem_en = commit && (cmd_reg == CMD_REMOVE) && found;
    assign ctrl.value  = value_reg;

    // Chain ends: the left end counts as occupied, the right end as empty
    assign head.value = '0;
    assign head.valid = 1'b1;
    assign head.gt    = 1'b0;
    assign tail.value = '0;
    assign tail.valid = 1'b0;
    assign tail.gt    = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smt_link_t left_link;
        smt_link_t right_link;

        if (i == 0)
        begin : g_first
            assign left_link = head;
        end
        else
        begin : g_inner_l
            assign left_link = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_link = tail;
        end
        else
        begin : g_inner_r
            assign right_link = links[i+1];
        end

        smt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .link  (links[i]),
            .eq    (eq_vec[i])
        );
    end

    smt_counter #(
        .CAPACITY (CAPACITY)
    ) u_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cnt_load),
        .flags (eq_vec),
        .done  (cnt_done),
        .total (occ)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_COMPARE;
            ST_COMPARE: state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_COUNT;
            ST_COUNT:   if (cnt_done) state_next = ST_UPDATE;
            ST_UPDATE:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Size and distinct counts after the operation
    always_comb
    begin
        count_next    = count_reg;
        distinct_next = distinct_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
            if (!found)
            begin
                distinct_next = distinct_reg + CNT_W'(1);
            end
        end
        else if (ctrl.rem_en)
        begin
            count_next = count_reg - CNT_W'(1);
            if (occ == CNT_W'(1))
            begin
                distinct_next = distinct_reg - CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            distinct_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            distinct_reg <= distinct_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            value_reg <= req.value;
        end
        if (commit)
        begin
            rsp_ok_reg       <= ok;
            rsp_occ_reg      <= FIELD_W'(occ);
            rsp_size_reg     <= FIELD_W'(count_next);
            rsp_distinct_reg <= FIELD_W'(distinct_next);
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.occurrences = rsp_occ_reg;
    assign rsp.size        = rsp_size_reg;
    assign rsp.distinct    = rsp_distinct_reg;

endmodule

`default_nettype wire

/* rtl/smt_cell.sv */
// One cell of the sorted chain: a stored value, its valid bit and the
// compare flags against the current item. Depends on smt_pkg.
`default_nettype none

module smt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  smt_pkg::smt_ctrl_t  ctrl,
    input  smt_pkg::smt_link_t  left,
    input  smt_pkg::smt_link_t  right,
    output smt_pkg::smt_link_t  link,
    output logic                eq
);
    import smt_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      gt_reg;
    logic                      ge_reg;
    logic                      eq_reg;
    logic                      take_ins;
    logic                      take_rem;

    // Insert: cells above the value move up one place, the first free cell fills
    assign take_ins = ctrl.ins_en && (gt_reg || (!valid_reg && left.valid));
    // Remove: from the first equal cell on, every occupied cell takes its right neighbor
    assign take_rem = ctrl.rem_en && ge_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (take_ins)
        begin
            value_next = left.gt ? left.value : ctrl.value;
            valid_next = 1'b1;
        end
        else if (take_rem)
        begin
            value_next = right.value;
            valid_next = right.valid;
        end
    end

    // Valid bit and compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp_en)
            begin
                gt_reg <= valid_reg && (value_reg > ctrl.value);
                ge_reg <= valid_reg && (value_reg >= ctrl.value);
                eq_reg <= valid_reg && (value_reg == ctrl.value);
            end
        end
    end

    // Stored value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.gt    = gt_reg;
    assign eq         = eq_reg;

endmodule

`default_nettype wire

/* rtl/smt_counter.sv */
// Match counter: sums the cells' equal flags, CHUNK flags per cycle, by
// shifting the captured flag row down. Depends on smt_pkg.
`default_nettype none

module smt_counter #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [CAPACITY-1:0]                flags,
    output logic                               done,
    output logic [$clog2(CAPACITY + 1)-1:0]    total
);
    import smt_pkg::*;

    localparam int STEPS  = (CAPACITY + CHUNK - 1) / CHUNK;
    localparam int PAD_W  = STEPS * CHUNK;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [PAD_W-1:0]  shift_reg;
    logic [STEP_W-1:0] left_reg;
    logic [CNT_W-1:0]  acc_reg;

    // Left count and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            acc_reg  <= '0;
        end
        else if (load)
        begin
            left_reg <= STEP_W'(STEPS);
            acc_reg  <= '0;
        end
        else if (left_reg != '0)
        begin
            left_reg <= left_reg - STEP_W'(1);
            acc_reg  <= acc_reg + CNT_W'(popcount_chunk(shift_reg[CHUNK-1:0]));
        end
    end

    // Flag row, consumed from the bottom
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= PAD_W'(flags);
        end
        else if (left_reg != '0)
        begin
            shift_reg <= shift_reg >> CHUNK;
        end
    end

    assign done  = (left_reg == '0);
    assign total = acc_reg;

endmodule

`default_nettype wire

/* rtl/smt_checker.sv */
// Port-level checks for sorted_multiset_table, attached by bind.
// Depends on smt_pkg for field widths.
`default_nettype none

module smt_checker #(
    parameter int CAPACITY = 64
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_ok,
    input logic [smt_pkg::FIELD_W-1:0] rsp_occ,
    input logic [smt_pkg::FIELD_W-1:0] rsp_size,
    input logic [smt_pkg::FIELD_W-1:0] rsp_distinct
);
    import smt_pkg::*;

    localparam bit NO_WRAP = (CAPACITY < 128);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its fields
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_occ)
            && $stable(rsp_size) && $stable(rsp_distinct))
        else $error("result changed while stalled");

    // One item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while one is in work");

    // Distinct values never outnumber entries
    a_distinct_le: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && NO_WRAP |-> rsp_distinct <= rsp_size)
        else $error("more distinct values than entries");

    // Empty table has no distinct values and vice versa
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && NO_WRAP |-> ((rsp_size == '0) == (rsp_distinct == '0)))
        else $error("size and distinct disagree on empty");

endmodule

bind sorted_multiset_table smt_checker #(
    .CAPACITY (CAPACITY)
) u_smt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_occ      (rsp.occurrences),
    .rsp_size     (rsp.size),
    .rsp_distinct (rsp.distinct)
);

`default_nettype wire
